// ===== src/ggs_pkg.sv =====
package ggs_pkg;

  localparam int COORD_W = 22;
  localparam logic [COORD_W-1:0] COORD_MAX = {COORD_W{1'b1}};

  localparam logic [20:0] CP_BOX_LO  = 21'h02500;
  localparam logic [20:0] CP_BOX_HI  = 21'h0257F;
  localparam logic [20:0] CP_BLK_LO  = 21'h02580;
  localparam logic [20:0] CP_BLK_HI  = 21'h0259F;
  localparam logic [20:0] CP_QUAD_LO = 21'h02596;
  localparam logic [20:0] CP_DOT_LO  = 21'h02800;
  localparam logic [20:0] CP_DOT_HI  = 21'h028FF;

  localparam logic [4:0] BO_UPPER_HALF   = 5'h00;
  localparam logic [4:0] BO_LOWER_LO     = 5'h01;
  localparam logic [4:0] BO_LOWER_HI     = 5'h08;
  localparam logic [4:0] BO_LEFT_LO      = 5'h09;
  localparam logic [4:0] BO_LEFT_HI      = 5'h0F;
  localparam logic [4:0] BO_RIGHT_HALF   = 5'h10;
  localparam logic [4:0] BO_SHADE_LO     = 5'h11;
  localparam logic [4:0] BO_SHADE_HI     = 5'h13;
  localparam logic [4:0] BO_UPPER_EIGHTH = 5'h14;
  localparam logic [4:0] BO_RIGHT_EIGHTH = 5'h15;
  localparam logic [4:0] BO_QUAD_LO      = 5'h16;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_RECT = 2'd1;
  localparam logic [1:0] KIND_CIRC = 2'd2;

  localparam logic [2:0] ALPHA_OPAQUE = 3'd4;

  localparam logic [2:0] CLS_NONE = 3'd0;
  localparam logic [2:0] CLS_LINE = 3'd1;
  localparam logic [2:0] CLS_RECT = 3'd2;
  localparam logic [2:0] CLS_QUAD = 3'd3;
  localparam logic [2:0] CLS_DOT  = 3'd4;

  localparam logic [1:0] CFG_CELL_W = 2'd0;
  localparam logic [1:0] CFG_CELL_H = 2'd1;
  localparam logic [1:0] CFG_SCALE  = 2'd2;

  localparam int NSLOT  = 11;
  localparam int SLOT_W = 4;
  localparam logic [SLOT_W-1:0] SL_P0  = 4'd0;
  localparam logic [SLOT_W-1:0] SL_P1  = 4'd1;
  localparam logic [SLOT_W-1:0] SL_P2  = 4'd2;
  localparam logic [SLOT_W-1:0] SL_P3  = 4'd3;
  localparam logic [SLOT_W-1:0] SL_Q0  = 4'd4;
  localparam logic [SLOT_W-1:0] SL_Q1  = 4'd5;
  localparam logic [SLOT_W-1:0] SL_Q2  = 4'd6;
  localparam logic [SLOT_W-1:0] SL_Q3  = 4'd7;
  localparam logic [SLOT_W-1:0] SL_Q4  = 4'd8;
  localparam logic [SLOT_W-1:0] SL_Q5  = 4'd9;
  localparam logic [SLOT_W-1:0] SL_RAD = 4'd10;

  localparam logic [2:0] LF_LEFT  = 3'd0;
  localparam logic [2:0] LF_RIGHT = 3'd1;
  localparam logic [2:0] LF_UP    = 3'd2;
  localparam logic [2:0] LF_DOWN  = 3'd3;
  localparam int         LF_HEAVY = 4;

  localparam logic [2:0] QD_TL = 3'd0;
  localparam logic [2:0] QD_TR = 3'd1;
  localparam logic [2:0] QD_BL = 3'd2;
  localparam logic [2:0] QD_BR = 3'd3;

  localparam int DOT_X0_Q8 = 72;
  localparam int DOT_X1_Q8 = 184;
  localparam int DOT_R_Q8  = 46;
  localparam int HALF_Q8   = 128;

  typedef struct packed {
    logic [20:0] codepoint;
    logic [12:0] cell_x;
    logic [12:0] cell_y;
    logic [23:0] fore_rgb;
  } ggs_in_t;

  typedef struct packed {
    logic         handled;
    logic [1:0]   shape_kind;
    logic [21:0]  left_or_center_x;
    logic [21:0]  top_or_center_y;
    logic [21:0]  right_or_radius;
    logic [21:0]  bottom_or_radius;
    logic [2:0]   alpha_quarters;
    logic [23:0]  fill_color;
    logic         last;
  } ggs_out_t;

  typedef struct packed {
    logic        handled;
    logic [2:0]  cls;
    logic [7:0]  mask;
    logic [2:0]  alpha;
    logic [23:0] fg;
  } ggs_entry_t;

  // {heavy, down, up, right, left}
  function automatic logic [4:0] line_flags(input logic [6:0] lo);
    logic [4:0] f;
    case (lo)
      7'h00, 7'h50:        f = 5'b0_0011;
      7'h01:               f = 5'b1_0011;
      7'h02, 7'h51:        f = 5'b0_1100;
      7'h03:               f = 5'b1_1100;
      7'h0C, 7'h54, 7'h6D: f = 5'b0_1010;
      7'h10, 7'h57, 7'h6E: f = 5'b0_1001;
      7'h14, 7'h5A, 7'h70: f = 5'b0_0110;
      7'h18, 7'h5D, 7'h6F: f = 5'b0_0101;
      7'h1C, 7'h60:        f = 5'b0_1110;
      7'h24, 7'h63:        f = 5'b0_1101;
      7'h2C, 7'h66:        f = 5'b0_1011;
      7'h34, 7'h69:        f = 5'b0_0111;
      7'h3C, 7'h6C:        f = 5'b0_1111;
      7'h74:               f = 5'b0_0001;
      7'h75:               f = 5'b0_0100;
      7'h76:               f = 5'b0_0010;
      7'h77:               f = 5'b0_1000;
      default:             f = 5'b0_0000;
    endcase
    return f;
  endfunction

  // bit 0 top left, 1 top right, 2 bottom left, 3 bottom right
  function automatic logic [3:0] quad_mask(input logic [3:0] i);
    logic [3:0] q;
    case (i)
      4'd0:    q = 4'd4;
      4'd1:    q = 4'd8;
      4'd2:    q = 4'd1;
      4'd3:    q = 4'd13;
      4'd4:    q = 4'd9;
      4'd5:    q = 4'd7;
      4'd6:    q = 4'd11;
      4'd7:    q = 4'd2;
      4'd8:    q = 4'd6;
      4'd9:    q = 4'd14;
      default: q = 4'd0;
    endcase
    return q;
  endfunction

  function automatic logic dot_col(input logic [2:0] i);
    return (i == 3'd3) || (i == 3'd4) || (i == 3'd5) || (i == 3'd7);
  endfunction

  function automatic logic [1:0] dot_row(input logic [2:0] i);
    logic [1:0] r;
    case (i)
      3'd0, 3'd3: r = 2'd0;
      3'd1, 3'd4: r = 2'd1;
      3'd2, 3'd5: r = 2'd2;
      default:    r = 2'd3;
    endcase
    return r;
  endfunction

endpackage

// ===== src/ggs_if.sv =====
interface ggs_in_if import ggs_pkg::*; ();
  logic    valid;
  logic    ready;
  ggs_in_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface ggs_out_if import ggs_pkg::*; ();
  logic     valid;
  logic     ready;
  ggs_out_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== src/ggs_front.sv =====
module ggs_front import ggs_pkg::*; #(
  parameter int FRAC_BITS = 8,
  parameter int CW        = 24
) (
  ggs_in_if.sink                       in_ch,
  input  logic [7:0]                   cell_width,
  input  logic [7:0]                   cell_height,
  input  logic [11:0]                  scale_q8,
  input  logic                         q_full,
  output logic                         q_push,
  output ggs_entry_t                   q_entry,
  output logic [NSLOT-1:0][CW-1:0]     q_coord
);

  logic [20:0]   cp;
  logic [4:0]    bo;
  logic [4:0]    lf;
  logic          is_box;
  logic          is_blk;
  logic          is_dot;
  logic [CW-1:0] xs, ys, wd, ht, wh, hh, xw, yh, h8;
  logic [4:0]    tp_raw, tp1;
  logic [5:0]    tp;
  logic [CW-1:0] th, xc, xct, yc, yct;
  logic [3:0]    nlow, nleft;
  logic [CW-1:0] top_lo, right_le, left_re;
  logic [CW-1:0] p72, p184, o72, o184, mm, pr, psc, rad;
  logic [CW-1:0] row0, row1, row2, row3;

  assign cp = in_ch.data.codepoint;
  assign bo = cp[4:0];

  always_comb begin
    xs = CW'(in_ch.data.cell_x) << FRAC_BITS;
    ys = CW'(in_ch.data.cell_y) << FRAC_BITS;
    wd = CW'(cell_width) << FRAC_BITS;
    ht = CW'(cell_height) << FRAC_BITS;
    wh = CW'(cell_width) << (FRAC_BITS - 1);
    hh = CW'(cell_height) << (FRAC_BITS - 1);
    h8 = CW'(cell_height) << (FRAC_BITS - 3);
    xw = xs + wd;
    yh = ys + ht;

    lf     = line_flags(cp[6:0]);
    tp_raw = 5'((13'(scale_q8) + 13'(HALF_Q8)) >> 8);
    tp1    = (tp_raw == 5'd0) ? 5'd1 : tp_raw;
    tp     = lf[LF_HEAVY] ? {tp1, 1'b0} : {1'b0, tp1};
    th     = CW'(tp) << (FRAC_BITS - 1);
    xc     = xs + wh - th;
    xct    = xs + wh + th;
    yc     = ys + hh - th;
    yct    = ys + hh + th;

    nlow     = 4'(BO_LOWER_HI - bo);
    nleft    = 4'(5'd16 - bo);
    top_lo   = ys + ((CW'(cell_height) * CW'(nlow)) << (FRAC_BITS - 3));
    right_le = xs + ((CW'(cell_width) * CW'(nleft)) << (FRAC_BITS - 3));
    left_re  = xs + ((CW'(cell_width) * CW'(7)) << (FRAC_BITS - 3));

    p72  = (CW'(cell_width) * CW'(DOT_X0_Q8)) << FRAC_BITS;
    p184 = (CW'(cell_width) * CW'(DOT_X1_Q8)) << FRAC_BITS;
    o72  = (p72 + CW'(HALF_Q8)) >> 8;
    o184 = (p184 + CW'(HALF_Q8)) >> 8;
    mm   = (wd < hh) ? wd : hh;
    pr   = (mm * CW'(DOT_R_Q8) + CW'(HALF_Q8)) >> 8;
    psc  = ((CW'(scale_q8) << FRAC_BITS) + CW'(HALF_Q8)) >> 8;
    rad  = (psc > pr) ? psc : pr;
    row0 = ys + h8;
    row1 = ys + (h8 * CW'(3));
    row2 = ys + (h8 * CW'(5));
    row3 = ys + (h8 * CW'(7));
  end

  always_comb begin
    is_box = cp inside {[CP_BOX_LO:CP_BOX_HI]};
    is_blk = cp inside {[CP_BLK_LO:CP_BLK_HI]};
    is_dot = cp inside {[CP_DOT_LO:CP_DOT_HI]};

    q_entry.cls   = CLS_NONE;
    q_entry.mask  = 8'd0;
    q_entry.alpha = ALPHA_OPAQUE;
    q_entry.fg    = in_ch.data.fore_rgb;

    q_coord[SL_P0]  = xs;
    q_coord[SL_P1]  = xs;
    q_coord[SL_P2]  = xw;
    q_coord[SL_P3]  = xw;
    q_coord[SL_Q0]  = ys;
    q_coord[SL_Q1]  = ys;
    q_coord[SL_Q2]  = yh;
    q_coord[SL_Q3]  = yh;
    q_coord[SL_Q4]  = row2;
    q_coord[SL_Q5]  = row3;
    q_coord[SL_RAD] = rad;

    if (is_box && (lf[3:0] != 4'd0)) begin
      q_entry.cls    = CLS_LINE;
      q_entry.mask   = {4'd0, lf[3:0]};
      q_coord[SL_P1] = xc;
      q_coord[SL_P2] = xct;
      q_coord[SL_Q1] = yc;
      q_coord[SL_Q2] = yct;
    end else if (is_blk) begin
      if (cp >= CP_QUAD_LO) begin
        q_entry.cls    = CLS_QUAD;
        q_entry.mask   = {4'd0, quad_mask(4'(bo - BO_QUAD_LO))};
        q_coord[SL_P1] = xs + wh;
        q_coord[SL_Q1] = ys + hh;
      end else begin
        q_entry.cls  = CLS_RECT;
        q_entry.mask = 8'd1;
        case (bo) inside
          BO_UPPER_HALF:               q_coord[SL_Q2] = ys + hh;
          [BO_LOWER_LO:BO_LOWER_HI]:   q_coord[SL_Q1] = top_lo;
          [BO_LEFT_LO:BO_LEFT_HI]:     q_coord[SL_P2] = right_le;
          BO_RIGHT_HALF:               q_coord[SL_P1] = xs + wh;
          [BO_SHADE_LO:BO_SHADE_HI]:   q_entry.alpha  = 3'(bo - BO_RIGHT_HALF);
          BO_UPPER_EIGHTH:             q_coord[SL_Q2] = ys + h8;
          BO_RIGHT_EIGHTH:             q_coord[SL_P1] = left_re;
          default: begin
          end
        endcase
      end
    end else if (is_dot) begin
      q_entry.cls    = CLS_DOT;
      q_entry.mask   = cp[7:0];
      q_coord[SL_P1] = xs + o72;
      q_coord[SL_P2] = xs + o184;
      q_coord[SL_Q1] = row0;
      q_coord[SL_Q2] = row1;
    end

    q_entry.handled = (q_entry.cls != CLS_NONE);
  end

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

endmodule

// ===== src/ggs_fifo.sv =====
module ggs_fifo import ggs_pkg::*; #(
  parameter int DEPTH = 4,
  parameter int W     = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic         full,
  output logic         empty,
  output logic [W-1:0] rdata
);

  localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNW = $clog2(DEPTH + 1);

  logic [W-1:0]   mem_r [DEPTH];
  logic [AW-1:0]  wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CNW-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    if (push) begin
      wp_nxt = (wp_r == AW'(DEPTH - 1)) ? AW'(0) : AW'(wp_r + AW'(1));
    end
    if (pop) begin
      rp_nxt = (rp_r == AW'(DEPTH - 1)) ? AW'(0) : AW'(rp_r + AW'(1));
    end
    cnt_nxt = CNW'(cnt_r + CNW'(push) - CNW'(pop));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wdata;
    end
  end

  assign full  = (cnt_r == CNW'(DEPTH));
  assign empty = (cnt_r == CNW'(0));
  assign rdata = mem_r[rp_r];

endmodule

// ===== src/ggs_back.sv =====
module ggs_back import ggs_pkg::*; #(
  parameter int CW = 24
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_empty,
  input  ggs_entry_t               head,
  input  logic [NSLOT-1:0][CW-1:0] head_coord,
  output logic                     q_pop,
  ggs_out_if.source                out_ch
);

  logic [7:0]        done_r, done_nxt;
  logic [7:0]        rem, pick;
  logic [2:0]        idx;
  logic              last;
  logic              load, emit;
  logic              out_valid_r, out_valid_nxt;
  ggs_out_t          out_data_r, res;
  logic [1:0]        kind;
  logic [SLOT_W-1:0] sl, st, sr, sb;

  function automatic logic [COORD_W-1:0] sat(input logic [CW-1:0] v);
    logic [COORD_W-1:0] s;
    if (v[CW-1]) begin
      s = '0;
    end else if (v > CW'(COORD_MAX)) begin
      s = COORD_MAX;
    end else begin
      s = v[COORD_W-1:0];
    end
    return s;
  endfunction

  function automatic logic [SLOT_W-1:0] row_slot(input logic [1:0] r);
    logic [SLOT_W-1:0] s;
    case (r)
      2'd0:    s = SL_Q1;
      2'd1:    s = SL_Q2;
      2'd2:    s = SL_Q4;
      default: s = SL_Q5;
    endcase
    return s;
  endfunction

  always_comb begin
    rem = head.mask & ~done_r;
    idx = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (rem[i]) begin
        idx = 3'(i);
      end
    end
    pick = 8'd1 << idx;
    last = ((rem & ~pick) == 8'd0);
  end

  always_comb begin
    kind = KIND_RECT;
    sl   = SL_P1;
    st   = SL_Q1;
    sr   = SL_P2;
    sb   = SL_Q2;
    case (head.cls)
      CLS_LINE: begin
        case (idx)
          LF_LEFT:  sl = SL_P0;
          LF_RIGHT: sr = SL_P3;
          LF_UP:    st = SL_Q0;
          LF_DOWN:  sb = SL_Q3;
          default: begin
          end
        endcase
      end
      CLS_QUAD: begin
        case (idx)
          QD_TL: begin
            sl = SL_P0; st = SL_Q0; sr = SL_P1; sb = SL_Q1;
          end
          QD_TR: begin
            sl = SL_P1; st = SL_Q0; sr = SL_P3; sb = SL_Q1;
          end
          QD_BL: begin
            sl = SL_P0; st = SL_Q1; sr = SL_P1; sb = SL_Q3;
          end
          default: begin
            sl = SL_P1; st = SL_Q1; sr = SL_P3; sb = SL_Q3;
          end
        endcase
      end
      CLS_DOT: begin
        kind = KIND_CIRC;
        sl   = dot_col(idx) ? SL_P2 : SL_P1;
        st   = row_slot(dot_row(idx));
        sr   = SL_RAD;
        sb   = SL_RAD;
      end
      CLS_RECT: begin
      end
      default: kind = KIND_NONE;
    endcase
    if (head.mask == 8'd0) begin
      kind = KIND_NONE;
    end
  end

  always_comb begin
    res.handled          = head.handled;
    res.shape_kind       = kind;
    res.left_or_center_x = (kind != KIND_NONE) ? sat(head_coord[sl]) : '0;
    res.top_or_center_y  = (kind != KIND_NONE) ? sat(head_coord[st]) : '0;
    res.right_or_radius  = (kind != KIND_NONE) ? sat(head_coord[sr]) : '0;
    res.bottom_or_radius = (kind != KIND_NONE) ? sat(head_coord[sb]) : '0;
    res.alpha_quarters   = (head.mask != 8'd0) ? head.alpha : 3'd0;
    res.fill_color       = (head.mask != 8'd0) ? head.fg : 24'd0;
    res.last             = last;
  end

  always_comb begin
    load          = !out_valid_r || out_ch.ready;
    emit          = load && !q_empty;
    q_pop         = emit && last;
    out_valid_nxt = load ? !q_empty : out_valid_r;
    done_nxt      = done_r;
    if (emit) begin
      done_nxt = last ? 8'd0 : (done_r | pick);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      done_r      <= 8'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      done_r      <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= res;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

endmodule

// ===== src/geometric_glyph_shape_generator.sv =====
// Box, block and braille glyph shape generator.
// in_ch carries one terminal cell per word (code point, pixel origin, color);
// out_ch carries the fill shapes for that cell, one per word, the final one
// flagged by last. An unhandled code point or blank braille gives one word
// with shape_kind none. Both channels move a word when valid and ready are
// high at a rising edge.
// cfg_we/cfg_index/cfg_wdata write cell width, cell height and scale; write
// them only while no cell is in flight.
// A taken cell goes into the queue, then the shape sequencer registers its
// first shape in the output word; it gives one shape per cycle while
// out_ch.ready allows, 1 to 8 shapes per cell. A queue of QUEUE_DEPTH cells
// sits between classifier and sequencer; in_ch.ready drops only when full.
// Reset: registers return to 8, 16 and 256 (scale 1.0), queue and output
// are empty. When out_ch.ready is low the output word holds, the sequencer
// stalls, and the queue keeps taking cells until it fills.
module geometric_glyph_shape_generator import ggs_pkg::*; #(
  parameter int FRAC_BITS   = 8,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  ggs_in_if.sink      in_ch,
  ggs_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_wdata
);

  localparam int CW = (FRAC_BITS + 16 > COORD_W + 1) ? FRAC_BITS + 16 : COORD_W + 1;
  localparam int EW = $bits(ggs_entry_t);
  localparam int QW = EW + NSLOT * CW;

  logic [7:0]               cell_width_r;
  logic [7:0]               cell_height_r;
  logic [11:0]              scale_q8_r;
  logic                     q_push, q_pop, q_full, q_empty;
  ggs_entry_t               push_entry, head_entry;
  logic [NSLOT-1:0][CW-1:0] push_coord, head_coord;
  logic [QW-1:0]            q_wdata, q_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_width_r  <= 8'd8;
      cell_height_r <= 8'd16;
      scale_q8_r    <= 12'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CELL_W: cell_width_r  <= cfg_wdata[7:0];
        CFG_CELL_H: cell_height_r <= cfg_wdata[7:0];
        CFG_SCALE:  scale_q8_r    <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  ggs_front #(
    .FRAC_BITS (FRAC_BITS),
    .CW        (CW)
  ) u_front (
    .in_ch       (in_ch),
    .cell_width  (cell_width_r),
    .cell_height (cell_height_r),
    .scale_q8    (scale_q8_r),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_entry     (push_entry),
    .q_coord     (push_coord)
  );

  assign q_wdata    = {push_entry, push_coord};
  assign head_entry = ggs_entry_t'(q_rdata[QW-1 -: EW]);
  assign head_coord = q_rdata[QW-EW-1:0];

  ggs_fifo #(
    .DEPTH (QUEUE_DEPTH),
    .W     (QW)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .full  (q_full),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  ggs_back #(
    .CW (CW)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .head       (head_entry),
    .head_coord (head_coord),
    .q_pop      (q_pop),
    .out_ch     (out_ch)
  );

`ifndef SYNTH
  a_none_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.data.shape_kind == KIND_NONE) |-> out_ch.data.last)
    else $error("empty shape word without last");

  a_unhandled_no_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.data.handled |-> out_ch.data.shape_kind == KIND_NONE)
    else $error("unhandled cell carries a shape");

  a_pop_gives_last: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> out_ch.valid && out_ch.data.last)
    else $error("queue entry retired without a last word");
`endif

endmodule
